### hdl/trsc_pkg.sv
// trsc_pkg: shared constants, codes and pipeline types of the three-rotor cipher
// used by the channel interfaces and by three_rotor_substitution_cipher
// no dependencies
package trsc_pkg;

  // alphabet size default and field widths
  localparam int SYMBOLS_DEF = 37;
  localparam int SYM_W       = 6;
  localparam int OP_W        = 2;
  localparam int WHEEL_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int POS_W       = 4;
  localparam int NUM_ROTORS  = 3;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2
  } op_t;

  // wiring table select codes
  localparam logic [WHEEL_W-1:0] WHEEL_FIRST  = 2'd0;
  localparam logic [WHEEL_W-1:0] WHEEL_SECOND = 2'd1;
  localparam logic [WHEEL_W-1:0] WHEEL_THIRD  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_THIRD  = 2'd2;

  // stepping thresholds of the position counter
  localparam logic [POS_W-1:0] POS_STEP_THIRD  = 4'd5;
  localparam logic [POS_W-1:0] POS_STEP_SECOND = 4'd9;
  localparam logic [POS_W-1:0] POS_STEP_FIRST  = 4'd13;
  localparam logic [POS_W-1:0] POS_MAX         = 4'd15;

  // per-item control and data carried down the lookup pipeline
  typedef struct packed {
    logic               cipher;
    logic               dec;
    logic               bad;
    logic               ld;
    logic [WHEEL_W-1:0] wheel;
    logic [SYM_W-1:0]   entry;
    logic [SYM_W-1:0]   sym;
    logic [SYM_W-1:0]   off1;
    logic [SYM_W-1:0]   off2;
    logic [SYM_W-1:0]   off3;
  } pipe_t;

endpackage

### hdl/trsc_in_if.sv
// trsc_in_if: input item channel (valid/ready plus item fields)
// depends on trsc_pkg
interface trsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [trsc_pkg::OP_W-1:0]     op;
  logic [trsc_pkg::WHEEL_W-1:0]  wheel_select;
  logic [trsc_pkg::SYM_W-1:0]    entry_index;
  logic [trsc_pkg::SYM_W-1:0]    symbol;
  logic                          end_of_message;

  modport source (output valid, op, wheel_select, entry_index, symbol, end_of_message,
                  input ready);
  modport sink (input valid, op, wheel_select, entry_index, symbol, end_of_message,
                output ready);
endinterface

### hdl/trsc_out_if.sv
// trsc_out_if: result item channel (valid/ready plus result fields)
// depends on trsc_pkg
interface trsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [trsc_pkg::SYM_W-1:0] result_symbol;
  logic                       bad_symbol;

  modport source (output valid, result_symbol, bad_symbol, input ready);
  modport sink (input valid, result_symbol, bad_symbol, output ready);
endinterface

### hdl/trsc_cfg_if.sv
// trsc_cfg_if: configuration write channel (valid/ready, register index, data)
// depends on trsc_pkg
interface trsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trsc_pkg::CFG_IDX_W-1:0] index;
  logic [trsc_pkg::SYM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/trsc_ram.sv
// trsc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module trsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port, read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/three_rotor_substitution_cipher.sv
// three_rotor_substitution_cipher: top level of the rotor cipher
// depends on trsc_pkg, trsc_in_if, trsc_out_if, trsc_cfg_if, trsc_ram

// Takes one item per clock and keeps that rate as long as results are taken.
// A cipher item's result comes from a chain of registers: the three
// wiring lookups are chained registered reads of six small rams (forward and
// inverse table of each wheel), one lookup per pipeline stage, and a final
// output register. A load writes each table in the same stage where ciphers
// read it, so loads and ciphers take effect strictly in item order with no
// interlock. Loads and op 3 produce no result. The wiring tables come up
// undefined after reset and must be loaded before use; there is no clearing
// pass. Rotor offsets and the position counter live in flops and step as a
// cipher item with a good symbol is accepted. Start offsets may be written
// only while the block is idle; a write also reloads that rotor's offset.
module three_rotor_substitution_cipher #(
  parameter int SYMBOLS = trsc_pkg::SYMBOLS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  trsc_in_if.sink    in_ch,
  trsc_out_if.source out_ch,
  trsc_cfg_if.sink   cfg_ch
);

  localparam int SYM_W  = trsc_pkg::SYM_W;
  localparam int POS_W  = trsc_pkg::POS_W;
  localparam int NROT   = trsc_pkg::NUM_ROTORS;
  localparam int ADDR_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [SYM_W:0]   N_EXT = (SYM_W + 1)'(SYMBOLS);
  localparam logic [SYM_W-1:0] N_TOP = SYM_W'(SYMBOLS - 1);

  // modular helpers, operands already below SYMBOLS
  function automatic logic [SYM_W-1:0] add_mod(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
    logic [SYM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= N_EXT) s = s - N_EXT;
    return s[SYM_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] sub_mod(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
    logic [SYM_W:0] s;
    s = {1'b0, a} + N_EXT - {1'b0, b};
    if (s >= N_EXT) s = s - N_EXT;
    return s[SYM_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] inc_mod(input logic [SYM_W-1:0] a);
    return (a == N_TOP) ? '0 : a + 1'b1;
  endfunction

  // key reduction table, raw 6-bit register value to value mod SYMBOLS
  logic [SYM_W-1:0] key_mod [2**SYM_W];
  for (genvar v = 0; v < 2**SYM_W; v++) begin : g_key_mod
    assign key_mod[v] = SYM_W'(v % SYMBOLS);
  end

  // state registers
  logic [SYM_W-1:0] key_r [NROT];
  logic [SYM_W-1:0] off_r [NROT];
  logic [SYM_W-1:0] off_nxt [NROT];
  logic [SYM_W-1:0] off_step [NROT];
  logic [POS_W-1:0] pos_r, pos_nxt;

  // pipeline registers
  logic                vb_r, vc_r, vd_r;
  trsc_pkg::pipe_t     pa, pb_r, pc_r, pd_r;
  logic                out_valid_r;
  logic [SYM_W-1:0]    out_sym_r;
  logic                out_bad_r;
  logic [SYM_W-1:0]    result;

  // handshake and decode
  logic en_a, en_b, en_c, en_d;
  logic in_accept, is_cipher, sym_bad, ld_ok, cfg_we;

  // ram ports
  logic [SYM_W-1:0]  fw0_q, fw1_q, fw2_q, inv0_q, inv1_q, inv2_q;
  logic [SYM_W-1:0]  fw0_ra, fw1_ra, fw2_ra, inv1_ra, inv0_ra;
  logic              fw0_we, fw1_we, fw2_we, inv0_we, inv1_we, inv2_we;

  // stage enables, a stage moves when the next one is empty or moving
  assign en_d = !out_valid_r || out_ch.ready;
  assign en_c = !vd_r || en_d;
  assign en_b = !vc_r || en_c;
  assign en_a = !vb_r || en_b;

  assign in_ch.ready = en_a;
  assign cfg_ch.ready = 1'b1;
  assign in_accept = in_ch.valid && en_a;
  assign cfg_we = cfg_ch.valid && (cfg_ch.index <= trsc_pkg::CFG_START_THIRD);

  // item decode
  assign is_cipher = (in_ch.op == trsc_pkg::OP_ENC) || (in_ch.op == trsc_pkg::OP_DEC);
  assign sym_bad   = ({1'b0, in_ch.symbol} >= N_EXT);
  assign ld_ok     = (in_ch.op == trsc_pkg::OP_LOAD)
                  && (in_ch.wheel_select <= trsc_pkg::WHEEL_THIRD)
                  && ({1'b0, in_ch.entry_index} < N_EXT) && !sym_bad;

  // rotor stepping ahead of the symbol
  assign off_step[2] = (pos_r >= trsc_pkg::POS_STEP_THIRD)  ? inc_mod(off_r[2]) : off_r[2];
  assign off_step[1] = (pos_r >= trsc_pkg::POS_STEP_SECOND) ? inc_mod(off_r[1]) : off_r[1];
  assign off_step[0] = (pos_r >= trsc_pkg::POS_STEP_FIRST)  ? inc_mod(off_r[0]) : off_r[0];

  // offset and position next state
  always_comb begin
    off_nxt = off_r;
    pos_nxt = pos_r;
    if (cfg_we) begin
      off_nxt[cfg_ch.index] = key_mod[cfg_ch.data];
    end
    if (in_accept && is_cipher) begin
      if (!sym_bad) begin
        off_nxt = off_step;
        if (pos_r != trsc_pkg::POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      if (in_ch.end_of_message) begin
        off_nxt = key_r;
        pos_nxt = '0;
      end
    end
  end

  // key, offset and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '{default: '0};
      off_r <= '{default: '0};
      pos_r <= '0;
    end else begin
      if (cfg_we) begin
        key_r[cfg_ch.index] <= key_mod[cfg_ch.data];
      end
      off_r <= off_nxt;
      pos_r <= pos_nxt;
    end
  end

  // stage a item word
  always_comb begin
    pa.cipher = is_cipher;
    pa.dec    = (in_ch.op == trsc_pkg::OP_DEC);
    pa.bad    = sym_bad;
    pa.ld     = ld_ok;
    pa.wheel  = in_ch.wheel_select;
    pa.entry  = in_ch.entry_index;
    pa.sym    = in_ch.symbol;
    pa.off1   = off_step[0];
    pa.off2   = off_step[1];
    pa.off3   = off_step[2];
  end

  // stage a: first lookup (forward wheel one, inverse wheel three)
  assign fw0_ra = sub_mod(in_ch.symbol, off_step[0]);
  assign fw0_we = in_accept && ld_ok && (in_ch.wheel_select == trsc_pkg::WHEEL_FIRST);
  assign inv2_we = in_accept && ld_ok && (in_ch.wheel_select == trsc_pkg::WHEEL_THIRD);

  trsc_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_fw0 (
    .clk(clk), .we(fw0_we), .waddr(in_ch.entry_index[ADDR_W-1:0]), .wdata(in_ch.symbol),
    .re(en_a), .raddr(fw0_ra[ADDR_W-1:0]), .rdata(fw0_q)
  );

  trsc_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_inv2 (
    .clk(clk), .we(inv2_we), .waddr(in_ch.symbol[ADDR_W-1:0]), .wdata(in_ch.entry_index),
    .re(en_a), .raddr(in_ch.symbol[ADDR_W-1:0]), .rdata(inv2_q)
  );

  // stage b: second lookup (forward wheel two, inverse wheel two)
  assign fw1_ra  = sub_mod(fw0_q, pb_r.off2);
  assign inv1_ra = add_mod(inv2_q, pb_r.off3);
  assign fw1_we  = en_b && vb_r && pb_r.ld && (pb_r.wheel == trsc_pkg::WHEEL_SECOND);
  assign inv1_we = fw1_we;

  trsc_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_fw1 (
    .clk(clk), .we(fw1_we), .waddr(pb_r.entry[ADDR_W-1:0]), .wdata(pb_r.sym),
    .re(en_b), .raddr(fw1_ra[ADDR_W-1:0]), .rdata(fw1_q)
  );

  trsc_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_inv1 (
    .clk(clk), .we(inv1_we), .waddr(pb_r.sym[ADDR_W-1:0]), .wdata(pb_r.entry),
    .re(en_b), .raddr(inv1_ra[ADDR_W-1:0]), .rdata(inv1_q)
  );

  // stage c: third lookup (forward wheel three, inverse wheel one)
  assign fw2_ra  = sub_mod(fw1_q, pc_r.off3);
  assign inv0_ra = add_mod(inv1_q, pc_r.off2);
  assign fw2_we  = en_c && vc_r && pc_r.ld && (pc_r.wheel == trsc_pkg::WHEEL_THIRD);
  assign inv0_we = en_c && vc_r && pc_r.ld && (pc_r.wheel == trsc_pkg::WHEEL_FIRST);

  trsc_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_fw2 (
    .clk(clk), .we(fw2_we), .waddr(pc_r.entry[ADDR_W-1:0]), .wdata(pc_r.sym),
    .re(en_c), .raddr(fw2_ra[ADDR_W-1:0]), .rdata(fw2_q)
  );

  trsc_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_inv0 (
    .clk(clk), .we(inv0_we), .waddr(pc_r.sym[ADDR_W-1:0]), .wdata(pc_r.entry),
    .re(en_c), .raddr(inv0_ra[ADDR_W-1:0]), .rdata(inv0_q)
  );

  // stage d: final offset for decrypt, zero for a bad symbol
  always_comb begin
    if (pd_r.bad) begin
      result = '0;
    end else if (pd_r.dec) begin
      result = add_mod(inv0_q, pd_r.off1);
    end else begin
      result = fw2_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) vb_r <= in_accept && (is_cipher || ld_ok);
      if (en_b) vc_r <= vb_r;
      if (en_c) vd_r <= vc_r && pc_r.cipher;
      if (en_d) out_valid_r <= vd_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en_a) pb_r <= pa;
    if (en_b) pc_r <= pb_r;
    if (en_c) pd_r <= pc_r;
    if (en_d) begin
      out_sym_r <= result;
      out_bad_r <= pd_r.bad;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_symbol = out_sym_r;
  assign out_ch.bad_symbol    = out_bad_r;

endmodule
